FILE: design/kptc_pkg.sv
// Package for the knob press-and-turn controller.
// Holds the field codes, register indexes, constants and the controller/datapath structs.
// No dependencies.
`default_nettype none

package kptc_pkg;

    localparam int DATA_IN_W  = 8;
    localparam int DATA_OUT_W = 32;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 12;

    typedef logic [1:0] t_mode;
    typedef logic [1:0] t_event;
    typedef logic [1:0] t_settle;

    localparam t_mode MODE_BRIGHT = 2'd0;
    localparam t_mode MODE_EFFECT = 2'd1;
    localparam t_mode MODE_OFF    = 2'd2;

    localparam t_event EV_NONE  = 2'd0;
    localparam t_event EV_SHORT = 2'd1;
    localparam t_event EV_LONG  = 2'd2;

    localparam t_settle SET_ZERO   = 2'd0;
    localparam t_settle SET_BRIGHT = 2'd1;
    localparam t_settle SET_EFFECT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_SETTLE = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EFFECT_SETTLE = 8'd3;

    // The step divisor and its rounded-up reciprocal scaled by two to the DIV_SHIFT.
    localparam logic [12:0] STEP_DIV  = 13'd4335;
    localparam logic [11:0] DIV_RECIP = 12'd3871;
    localparam int          DIV_SHIFT = 24;
    localparam logic [5:0]  STEP_BASE = 6'd3;

    typedef struct packed {
        logic tick;
        logic sq;
        logic div;
        logic corr;
        logic mul;
        logic clamp;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic need_push;
    } t_status;

endpackage

`default_nettype wire

FILE: design/knob_press_and_turn_controller.sv
// Top level of the knob press-and-turn controller.
// Joins the controller state machine and the datapath. Depends on kptc_pkg,
// kptc_ctrl and kptc_datapath.
//
//  channel   direction  handshake                      payload
//  s_axis    in         s_axis_tvalid / s_axis_tready  button level, count change
//  m_axis    out        m_axis_tvalid / m_axis_tready  mode, brightness, effect, flags
//  cfg       in         i_cfg_valid / o_cfg_ready      register index, write data
//
// A tick that leaves the brightness alone goes straight to the output load stage; one
// that applies rotation in brightness mode first passes through the square, reciprocal divide,
// correction, multiply and clamp stages of the step calculation. The next tick is accepted as
// soon as the result sits in the output register, even while it waits there.
// Reset is synchronous and active low; the output stalls only the final load stage.
`default_nettype none

module knob_press_and_turn_controller #(
    parameter int AGE_WIDTH = 16
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    // [0] button_level, [6:1] count_delta, [7] zero
    input  wire [kptc_pkg::DATA_IN_W-1:0]    s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    // [1:0] mode, [9:2] brightness, [25:10] effect_index, [26] display_on,
    // [28:27] button_event, [29] rotation_applied, [31:30] zero
    output logic [kptc_pkg::DATA_OUT_W-1:0]  m_axis_tdata,
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire [kptc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire [kptc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import kptc_pkg::*;

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    kptc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    kptc_datapath #(
        .AGE_WIDTH (AGE_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_level     (s_axis_tdata[0]),
        .i_delta     ($signed(s_axis_tdata[6:1])),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_data      (m_axis_tdata)
    );

endmodule

`default_nettype wire

FILE: design/kptc_ctrl.sv
// Controller state machine of the knob press-and-turn controller.
// Sequences the tick update, the brightness step pipeline and the output register.
// Depends on kptc_pkg.
`default_nettype none

module kptc_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  wire              i_out_ready,
    input  kptc_pkg::t_status i_status,
    output kptc_pkg::t_cmd   o_cmd
);
    import kptc_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_SQ    = 7'b0000010,
        ST_DIV   = 7'b0000100,
        ST_CORR  = 7'b0001000,
        ST_MUL   = 7'b0010000,
        ST_CLAMP = 7'b0100000,
        ST_OUT   = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        o_cmd       = '0;
        n_state     = r_state;
        o_in_ready  = (r_state == ST_IDLE);
        o_cmd.tick  = (r_state == ST_IDLE) && i_in_valid;
        o_cmd.sq    = (r_state == ST_SQ);
        o_cmd.div   = (r_state == ST_DIV);
        o_cmd.corr  = (r_state == ST_CORR);
        o_cmd.mul   = (r_state == ST_MUL);
        o_cmd.clamp = (r_state == ST_CLAMP);
        o_cmd.load  = (r_state == ST_OUT) && (!r_out_valid || i_out_ready);
        case (r_state)
            ST_IDLE: begin
                if (o_cmd.tick) begin
                    n_state = i_status.need_push ? ST_SQ : ST_OUT;
                end
            end
            ST_SQ:    n_state = ST_DIV;
            ST_DIV:   n_state = ST_CORR;
            ST_CORR:  n_state = ST_MUL;
            ST_MUL:   n_state = ST_CLAMP;
            ST_CLAMP: n_state = ST_OUT;
            ST_OUT: begin
                if (o_cmd.load) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
        n_out_valid = r_out_valid;
        if (o_cmd.load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_push_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.tick && i_status.need_push) |=> (r_state == ST_SQ))
        else $error("brightness update not started after tick");

    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_out_valid)
        else $error("output not valid after load");

    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.tick |=> !o_in_ready)
        else $error("input ready again directly after a transaction");

endmodule

`default_nettype wire

FILE: design/kptc_datapath.sv
// Datapath of the knob press-and-turn controller.
// Holds the configuration, button and rotation state, the brightness step pipeline
// and the output register. Depends on kptc_pkg.
`default_nettype none

module kptc_datapath #(
    parameter int AGE_WIDTH = 16
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  kptc_pkg::t_cmd                      i_cmd,
    output kptc_pkg::t_status                   o_status,
    input  wire                                 i_level,
    input  wire signed [5:0]                    i_delta,
    input  wire                                 i_cfg_we,
    input  wire [kptc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire [kptc_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output logic [kptc_pkg::DATA_OUT_W-1:0]     o_data
);
    import kptc_pkg::*;

    localparam int CW = (AGE_WIDTH > 12) ? AGE_WIDTH : 12;

    function automatic logic [AGE_WIDTH-1:0] age_inc(input logic [AGE_WIDTH-1:0] a);
        return (&a) ? a : a + 1'b1;
    endfunction

    logic [9:0]  r_debounce, r_bset, r_eset;
    logic [11:0] r_long;

    logic                 r_last_level, n_last_level;
    logic [AGE_WIDTH-1:0] r_edge_age, n_edge_age;
    logic [AGE_WIDTH-1:0] r_press_age, n_press_age;
    logic [AGE_WIDTH-1:0] r_quiet_age, n_quiet_age;
    logic                 r_held, n_held;
    logic                 r_released, n_released;
    logic                 r_done, n_done;
    logic signed [15:0]   r_delta_sum, n_delta_sum;
    logic                 r_pending, n_pending;
    t_settle              r_settle, n_settle;
    t_mode                r_mode, n_mode;
    logic [15:0]          r_effect, n_effect;
    logic                 r_display, n_display;
    logic                 r_counting, n_counting;
    t_event               r_event, n_event;
    logic                 r_applied, n_applied;
    logic                 n_push;

    logic [7:0]           r_bright;
    logic signed [15:0]   r_push_sum;
    logic [15:0]          r_sq;
    logic [4:0]           r_qest;
    logic [5:0]           r_step;
    logic signed [23:0]   r_bsum;
    logic [DATA_OUT_W-1:0] r_out;

    logic [AGE_WIDTH-1:0] age_e;
    logic                 edge_ok;
    logic signed [16:0]   sum_ext;
    logic [9:0]           limit;

    always_comb begin
        n_last_level = i_level;
        n_press_age  = age_inc(r_press_age);
        n_held       = r_held;
        n_released   = r_released;
        n_done       = r_done;
        age_e        = age_inc(r_edge_age);
        edge_ok      = (i_level != r_last_level) && (CW'(age_e) >= CW'(r_debounce));
        n_edge_age   = edge_ok ? '0 : age_e;
        if (edge_ok) begin
            if (!i_level) begin
                n_press_age = '0;
                n_held      = 1'b1;
                n_done      = 1'b0;
                n_released  = 1'b0;
            end else begin
                n_held      = 1'b0;
                n_released  = 1'b1;
            end
        end

        n_event = EV_NONE;
        if (!n_done) begin
            if (n_held && (CW'(n_press_age) >= CW'(r_long))) begin
                n_event = EV_LONG;
                n_done  = 1'b1;
            end
            if (!n_done && n_released) begin
                n_event = (CW'(n_press_age) < CW'(r_long)) ? EV_SHORT : EV_LONG;
                n_done  = 1'b1;
            end
        end

        n_quiet_age = age_inc(r_quiet_age);
        n_delta_sum = r_delta_sum;
        n_pending   = r_pending;
        sum_ext     = {r_delta_sum[15], r_delta_sum} + {{11{i_delta[5]}}, i_delta};
        if (r_counting && (i_delta != 6'sd0)) begin
            if (sum_ext[16] != sum_ext[15]) begin
                n_delta_sum = sum_ext[16] ? 16'sh8000 : 16'sh7fff;
            end else begin
                n_delta_sum = sum_ext[15:0];
            end
            n_pending   = 1'b1;
            n_quiet_age = '0;
        end
        case (r_settle)
            SET_BRIGHT: limit = r_bset;
            SET_EFFECT: limit = r_eset;
            default:    limit = 10'd0;
        endcase
        n_applied = 1'b0;
        if (n_pending && (CW'(n_quiet_age) >= CW'(limit))) begin
            n_pending = 1'b0;
            n_applied = 1'b1;
        end

        n_mode     = r_mode;
        n_settle   = r_settle;
        n_display  = r_display;
        n_counting = r_counting;
        if (n_event == EV_SHORT) begin
            if (r_mode == MODE_BRIGHT) begin
                n_mode   = MODE_EFFECT;
                n_settle = SET_EFFECT;
            end else if (r_mode == MODE_EFFECT) begin
                n_mode   = MODE_BRIGHT;
                n_settle = SET_BRIGHT;
            end else begin
                n_display  = !r_display;
                n_mode     = MODE_BRIGHT;
                n_settle   = SET_BRIGHT;
                n_counting = 1'b1;
            end
        end else if (n_event == EV_LONG) begin
            n_mode     = MODE_OFF;
            n_display  = !r_display;
            n_counting = 1'b0;
        end

        n_effect = r_effect;
        n_push   = 1'b0;
        if (n_applied) begin
            if (n_mode == MODE_BRIGHT) begin
                n_push = 1'b1;
            end else if (n_mode == MODE_EFFECT) begin
                n_effect = r_effect + n_delta_sum;
            end
        end
    end

    assign o_status.need_push = n_push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= 10'd50;
            r_long     <= 12'd500;
            r_bset     <= 10'd40;
            r_eset     <= 10'd150;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_DEBOUNCE:      r_debounce <= i_cfg_data[9:0];
                REG_LONG_PRESS:    r_long     <= i_cfg_data;
                REG_BRIGHT_SETTLE: r_bset     <= i_cfg_data[9:0];
                REG_EFFECT_SETTLE: r_eset     <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_level <= 1'b1;
            r_edge_age   <= '1;
            r_press_age  <= '0;
            r_quiet_age  <= '0;
            r_held       <= 1'b0;
            r_released   <= 1'b0;
            r_done       <= 1'b1;
            r_delta_sum  <= '0;
            r_pending    <= 1'b0;
            r_settle     <= SET_ZERO;
            r_mode       <= MODE_OFF;
            r_effect     <= '0;
            r_display    <= 1'b1;
            r_counting   <= 1'b1;
            r_event      <= EV_NONE;
            r_applied    <= 1'b0;
        end else if (i_cmd.tick) begin
            r_last_level <= n_last_level;
            r_edge_age   <= n_edge_age;
            r_press_age  <= n_press_age;
            r_quiet_age  <= n_quiet_age;
            r_held       <= n_held;
            r_released   <= n_released;
            r_done       <= n_done;
            r_delta_sum  <= n_applied ? 16'sd0 : n_delta_sum;
            r_pending    <= n_pending;
            r_settle     <= n_settle;
            r_mode       <= n_mode;
            r_effect     <= n_effect;
            r_display    <= n_display;
            r_counting   <= n_counting;
            r_event      <= n_event;
            r_applied    <= n_applied;
        end
    end

    logic [16:0]        sq_x;
    logic [28:0]        div_prod;
    logic [17:0]        div_chk;
    logic [4:0]         q_fix;
    logic signed [23:0] mul_prod;

    assign sq_x     = {r_sq, 1'b0};
    assign div_prod = 29'(sq_x) * 29'(DIV_RECIP);
    assign div_chk  = 18'(r_qest) * 18'(STEP_DIV);
    assign q_fix    = (div_chk > 18'(sq_x)) ? r_qest - 5'd1 : r_qest;
    assign mul_prod = 24'(r_push_sum) * $signed({18'd0, r_step});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bright <= '0;
        end else if (i_cmd.clamp) begin
            if (r_bsum < 24'sd1) begin
                r_bright <= 8'd1;
            end else if (r_bsum > 24'sd255) begin
                r_bright <= 8'd255;
            end else begin
                r_bright <= r_bsum[7:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tick) begin
            r_push_sum <= n_delta_sum;
        end
        if (i_cmd.sq) begin
            r_sq <= 16'(r_bright) * 16'(r_bright);
        end
        if (i_cmd.div) begin
            r_qest <= div_prod[DIV_SHIFT+4:DIV_SHIFT];
        end
        if (i_cmd.corr) begin
            r_step <= 6'(q_fix) + STEP_BASE;
        end
        if (i_cmd.mul) begin
            r_bsum <= mul_prod + $signed({16'd0, r_bright});
        end
        if (i_cmd.load) begin
            r_out <= {2'b00, r_applied, r_event, r_display, r_effect, r_bright, r_mode};
        end
    end

    assign o_data = r_out;

endmodule

`default_nettype wire

FILE: verif/knob_press_and_turn_controller_tb.sv
// Self-checking testbench for knob_press_and_turn_controller: millisecond ticks go in on the
// input stream and every result on the output stream is compared against a tick-by-tick model.
// Depends on kptc_pkg and the controller RTL only.
`timescale 1ns / 100ps

module knob_press_and_turn_controller_tb;
    import kptc_pkg::*;

    localparam int          AGE_WIDTH        = 16;
    localparam int unsigned AGE_TOP          = (1 << AGE_WIDTH) - 1;
    localparam int          BRIGHT_STEP_BASE = 3;
    localparam int          BRIGHT_STEP_DIV  = 4335;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'd9;

    typedef struct {
        t_mode       mode;
        logic [7:0]  bright;
        logic [15:0] effect;
        logic        disp;
        t_event      ev;
        logic        applied;
    } t_knob_reading;

    // Tracks the controller state tick by tick and holds the readings it expects back.
    class t_knob_tracker;
        int unsigned   debounce_ticks, long_ticks, bright_settle, effect_settle;
        logic          prev_level;
        int unsigned   since_edge, hold_age, quiet_ticks;
        bit            held, released, press_closed, turn_waiting, counting;
        int            turn_sum;
        t_settle       settle_sel;
        t_mode         mode_now;
        int            bright_now;
        logic [15:0]   effect_now;
        logic          disp_now;
        t_knob_reading pending_readings[$];
        int            n_ticks, n_errors, n_short, n_long, n_applied, n_writes;

        function new();
            debounce_ticks = 50;
            long_ticks     = 500;
            bright_settle  = 40;
            effect_settle  = 150;
            prev_level     = 1'b1;
            since_edge     = AGE_TOP;
            hold_age       = 0;
            quiet_ticks    = 0;
            held           = 0;
            released       = 0;
            press_closed   = 1;
            turn_waiting   = 0;
            counting       = 1;
            turn_sum       = 0;
            settle_sel     = SET_ZERO;
            mode_now       = MODE_OFF;
            bright_now     = 0;
            effect_now     = '0;
            disp_now       = 1'b1;
        endfunction

        function int unsigned age_step(int unsigned a);
            return (a >= AGE_TOP) ? AGE_TOP : a + 1;
        endfunction

        function int unsigned settle_ticks();
            case (settle_sel)
                SET_BRIGHT: return bright_settle;
                SET_EFFECT: return effect_settle;
                default:    return 0;
            endcase
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            n_writes++;
            case (idx)
                REG_DEBOUNCE:      debounce_ticks = val[9:0];
                REG_LONG_PRESS:    long_ticks     = val;
                REG_BRIGHT_SETTLE: bright_settle  = val[9:0];
                REG_EFFECT_SETTLE: effect_settle  = val[9:0];
                default: ;
            endcase
        endfunction

        function void take_tick(logic lvl, logic signed [5:0] d);
            int unsigned   age;
            t_event        ev;
            bit            applied;
            int            sum, b, stp, v;
            t_knob_reading r;
            ev      = EV_NONE;
            applied = 0;

            age      = age_step(since_edge);
            hold_age = age_step(hold_age);
            if (lvl != prev_level && age >= debounce_ticks) begin
                since_edge = 0;
                if (!lvl) begin
                    hold_age     = 0;
                    held         = 1;
                    press_closed = 0;
                    released     = 0;
                end else begin
                    held     = 0;
                    released = 1;
                end
            end else begin
                since_edge = age;
            end
            prev_level = lvl;

            if (!press_closed) begin
                if (held && hold_age >= long_ticks) begin
                    ev           = EV_LONG;
                    press_closed = 1;
                end
                if (!press_closed && released) begin
                    ev           = (hold_age < long_ticks) ? EV_SHORT : EV_LONG;
                    press_closed = 1;
                end
            end

            quiet_ticks = age_step(quiet_ticks);
            if (counting && d != 0) begin
                sum = turn_sum + int'(d);
                if (sum > 32767) sum = 32767;
                if (sum < -32768) sum = -32768;
                turn_sum     = sum;
                turn_waiting = 1;
                quiet_ticks  = 0;
            end
            if (turn_waiting && quiet_ticks >= settle_ticks()) begin
                turn_waiting = 0;
                applied      = 1;
            end

            case (ev)
                EV_SHORT: begin
                    n_short++;
                    case (mode_now)
                        MODE_BRIGHT: begin
                            mode_now   = MODE_EFFECT;
                            settle_sel = SET_EFFECT;
                        end
                        MODE_EFFECT: begin
                            mode_now   = MODE_BRIGHT;
                            settle_sel = SET_BRIGHT;
                        end
                        default: begin
                            disp_now   = !disp_now;
                            mode_now   = MODE_BRIGHT;
                            settle_sel = SET_BRIGHT;
                            counting   = 1;
                        end
                    endcase
                end
                EV_LONG: begin
                    n_long++;
                    mode_now = MODE_OFF;
                    disp_now = !disp_now;
                    counting = 0;
                end
                default: ;
            endcase

            if (applied) begin
                n_applied++;
                if (mode_now == MODE_BRIGHT) begin
                    b   = bright_now;
                    stp = BRIGHT_STEP_BASE + (2 * b * b) / BRIGHT_STEP_DIV;
                    v   = b + turn_sum * stp;
                    if (v < 1) v = 1;
                    if (v > 255) v = 255;
                    bright_now = v;
                end else if (mode_now == MODE_EFFECT) begin
                    effect_now = effect_now + turn_sum[15:0];
                end
                turn_sum = 0;
            end

            r.mode    = mode_now;
            r.bright  = bright_now[7:0];
            r.effect  = effect_now;
            r.disp    = disp_now;
            r.ev      = ev;
            r.applied = applied;
            pending_readings.push_back(r);
            n_ticks++;
        endfunction

        function void cmp_field(string name, int unsigned exp_v, int unsigned got_v);
            if (exp_v != got_v) begin
                n_errors++;
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
            end
        endfunction

        function void match_reading(logic [DATA_OUT_W-1:0] data);
            t_knob_reading e;
            if (pending_readings.size() == 0) begin
                n_errors++;
                $display("%0t: result with no tick outstanding, expected none, got %h",
                         $time, data);
                return;
            end
            e = pending_readings.pop_front();
            cmp_field("mode", e.mode, data[1:0]);
            cmp_field("brightness", e.bright, data[9:2]);
            cmp_field("effect_index", e.effect, data[25:10]);
            cmp_field("display_on", e.disp, data[26]);
            cmp_field("button_event", e.ev, data[28:27]);
            cmp_field("rotation_applied", e.applied, data[29]);
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [DATA_IN_W-1:0]  s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [DATA_OUT_W-1:0] m_axis_tdata;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    t_knob_tracker sb;
    bit          no_gaps   = 0;
    logic        drv_level = 1'b1;
    int          n_sent    = 0;

    knob_press_and_turn_controller #(
        .AGE_WIDTH(AGE_WIDTH)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function int rand_delta();
        if ($urandom_range(0, 15) == 0) return int'($urandom_range(0, 63)) - 32;
        return int'($urandom_range(0, 42)) - 21;
    endfunction

    task send_tick(input logic lvl, input int d);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, 6'(d), lvl};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.take_tick(lvl, 6'(d));
        n_sent++;
        drv_level = lvl;
    endtask

    task drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_readings.size() != 0) @(posedge i_clk);
    endtask

    task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        drain();
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.set_register(idx, val);
    endtask

    task set_phase(input logic [CFG_DATA_W-1:0] db, input logic [CFG_DATA_W-1:0] lp,
                   input logic [CFG_DATA_W-1:0] bs, input logic [CFG_DATA_W-1:0] es);
        write_reg(REG_DEBOUNCE, db);
        write_reg(REG_LONG_PRESS, lp);
        write_reg(REG_BRIGHT_SETTLE, bs);
        write_reg(REG_EFFECT_SETTLE, es);
    endtask

    // Released long enough to clear the lockout, then held for the given ticks but at least the lockout and one tick.
    task press_for(input int hold, input bit turning);
        repeat (sb.debounce_ticks + 1) send_tick(1'b1, turning ? rand_delta() : 0);
        if (hold < int'(sb.debounce_ticks)) hold = sb.debounce_ticks;
        if (hold < 1) hold = 1;
        repeat (hold) send_tick(1'b0, turning ? rand_delta() : 0);
        send_tick(1'b1, turning ? rand_delta() : 0);
    endtask

    task random_gestures(input int count);
        int start, pick, len;
        start = n_sent;
        while (n_sent - start < count) begin
            no_gaps = ($urandom_range(0, 7) == 0);
            pick    = $urandom_range(0, 9);
            if (pick < 3 && (sb.debounce_ticks > 40 || sb.long_ticks > 40)) pick = 9;
            case (pick)
                0, 1: press_for($urandom_range(1, (sb.long_ticks > 1) ? sb.long_ticks - 1 : 1),
                                $urandom_range(0, 1));
                2: press_for(sb.long_ticks + $urandom_range(0, 3), $urandom_range(0, 1));
                3, 4, 5: repeat ($urandom_range(1, 8)) send_tick(drv_level, rand_delta());
                6, 7: begin
                    len = sb.settle_ticks() + 2;
                    if (len > 40) len = 40;
                    repeat ($urandom_range(0, len)) send_tick(drv_level, 0);
                end
                8: repeat ($urandom_range(2, 6)) send_tick($urandom_range(0, 1), 0);
                default: repeat ($urandom_range(1, 6))
                    send_tick($urandom_range(0, 1), int'($urandom_range(0, 63)) - 32);
            endcase
        end
        no_gaps = 0;
    endtask

    initial begin
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            int stall;
            stall = no_gaps ? 0 : $urandom_range(0, 14);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            sb.match_reading(m_axis_tdata);
        end
    end

    initial begin
        sb = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: rotation while off, a press, and edges inside the lockout.
        send_tick(1'b1, 21);
        send_tick(1'b1, -21);
        send_tick(1'b0, 1);
        send_tick(1'b1, 0);
        send_tick(1'b0, 0);

        // Short settings: short presses through the modes, rotation that cancels out in effect mode,
        // brightness clamped at the low end, then a long press that pauses counting and a late release.
        set_phase(1, 4, 2, 3);
        send_tick(1'b1, 0);
        send_tick(1'b1, 5);
        send_tick(1'b0, 0);
        send_tick(1'b1, 0);
        send_tick(1'b1, -21);
        repeat (2) send_tick(1'b1, 0);
        send_tick(1'b1, 21);
        repeat (2) send_tick(1'b1, 0);
        send_tick(1'b0, 0);
        send_tick(1'b1, 0);
        send_tick(1'b1, -1);
        repeat (3) send_tick(1'b1, 0);
        repeat (5) send_tick(1'b0, 0);
        send_tick(1'b1, 0);

        set_phase(3, 12, 4, 7);
        random_gestures(350);

        // Zero lockout, zero hold threshold and zero settle, plus a write to no register.
        set_phase(0, 0, 0, 0);
        write_reg(REG_UNUSED, 12'hABC);
        random_gestures(150);

        // Upper bits above the register widths must be dropped.
        set_phase(12'hC02, 1, 12'h801, 12'h400);
        random_gestures(150);

        set_phase(5, 30, 10, 20);
        random_gestures(300);

        set_phase(1023, 4095, 1023, 1023);
        random_gestures(60);

        drain();
        repeat (20) @(posedge i_clk);
        $display("Checked %0d ticks across %0d register writes, from zero to full-scale settings.",
                 sb.n_ticks, sb.n_writes);
        $display("Saw %0d short and %0d long presses; rotation was applied %0d times.",
                 sb.n_short, sb.n_long, sb.n_applied);
        if (sb.n_errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
